FILE: rtl/gf2pm_pkg.sv
package gf2pm_pkg;

    // Number of 64-bit words in each operand; the product has twice as many.
    localparam int OPERAND_WORDS = 96;
    localparam int PRODUCT_WORDS = 2 * OPERAND_WORDS;

    localparam int WORD_W = 64;
    localparam int HALF_W = WORD_W / 2;

    // Address widths of the operand and product stores.
    localparam int OAW = (OPERAND_WORDS > 1) ? $clog2(OPERAND_WORDS) : 1;
    localparam int PAW = $clog2(PRODUCT_WORDS);
    // The column counter also holds OPERAND_WORDS for the row tail step.
    localparam int JW  = $clog2(OPERAND_WORDS + 1);

    // Operation codes.
    localparam logic [1:0] OP_LOAD     = 2'd0;
    localparam logic [1:0] OP_MULTIPLY = 2'd1;
    localparam logic [1:0] OP_READ     = 2'd2;

    typedef struct packed {
        logic [1:0]        operation;
        logic [7:0]        word_index;
        logic [WORD_W-1:0] a_word;
        logic [WORD_W-1:0] b_word;
    } t_cmd;

    typedef struct packed {
        logic [WORD_W-1:0] product_word;
        logic              done_res;
    } t_result;

    // The four 32x32 carry-less partial products of one word pair.
    typedef struct packed {
        logic [WORD_W-1:0] hh;
        logic [WORD_W-1:0] hl;
        logic [WORD_W-1:0] lh;
        logic [WORD_W-1:0] ll;
    } t_partials;

    // 32x32 -> 64-bit carry-less product; the shifted terms are independent.
    function automatic logic [WORD_W-1:0] clmul32(input logic [HALF_W-1:0] x,
                                                  input logic [HALF_W-1:0] y);
        logic [WORD_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < HALF_W; k++) begin
            if (y[k]) begin
                acc = acc ^ ({{HALF_W{1'b0}}, x} << k);
            end
        end
        return acc;
    endfunction

endpackage

FILE: rtl/gf2pm_ram.sv
module gf2pm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 96
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write and one registered read per cycle; a read of the entry being
    // written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/gf2_polynomial_multiplier_unit.sv
// Carry-less (GF(2)) multiplier of two binary polynomials of OPERAND_WORDS
// 64-bit words each, least significant word first.
// Requests are taken when i_start is high and o_busy is low. A load with an
// index below OPERAND_WORDS writes one word of each operand and gives no
// result. A read returns one product word on o_result with o_strobe high in
// the cycle after the request; while o_busy is low, loads and reads stream
// at one request per cycle. A multiply walks the schoolbook schedule row by
// row: each row i reads A[i], B[j] and the partial product word i+j for
// j = 0..N-1 plus one tail step, so it issues N*(N+1) memory steps, one per
// cycle, through a three stage read, partial product, combine and write-back
// pipeline. o_busy stays high until the pipeline has drained, and the done
// result (product_word zero, done_res one) appears in the same cycle as
// o_busy falls.
// Results last exactly one cycle; the receiver cannot stall them.
// Reset clears the control state only; the stores hold garbage until
// written, so every operand word must be loaded before a multiply.
module gf2_polynomial_multiplier_unit
    import gf2pm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_cmd    i_cmd,
    output logic    o_busy,
    output logic    o_strobe,
    output t_result o_result
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0]     r_state, n_state;
    logic [OAW-1:0] r_i, n_i;
    logic [JW-1:0]  r_j, n_j;

    logic accept;
    logic do_load, do_mul, do_read;
    logic issue, tail, last_row;

    logic [WORD_W-1:0] a_dout, b_dout, p_dout;
    logic [PAW-1:0]    p_raddr, issue_addr;

    // Stage 1: memory data arrives.
    logic           r_s1_v;
    logic [PAW-1:0] r_s1_addr;
    logic           r_s1_zold, r_s1_tail, r_s1_j0;

    // Stage 2: partial products registered, combine and write back.
    logic              r_s2_v;
    logic [PAW-1:0]    r_s2_addr;
    logic              r_s2_j0;
    t_partials         r_pp;
    logic [WORD_W-1:0] r_old;
    logic [WORD_W-1:0] r_carry;
    logic [2*WORD_W-1:0] prod;
    logic [WORD_W-1:0] carry_in, new_word;

    // Read result tracking.
    logic r_rd_pend, r_rd_zero, r_done, n_done;

    assign accept  = i_start && !o_busy;
    assign do_load = accept && (i_cmd.operation == OP_LOAD)
                     && ({2'b00, i_cmd.word_index} < 10'(OPERAND_WORDS));
    assign do_mul  = accept && (i_cmd.operation == OP_MULTIPLY);
    assign do_read = accept && (i_cmd.operation == OP_READ);

    assign issue    = (r_state == S_RUN);
    assign tail     = (r_j == JW'(OPERAND_WORDS));
    assign last_row = (r_i == OAW'(OPERAND_WORDS - 1));
    assign issue_addr = PAW'(r_i) + PAW'(r_j);
    assign p_raddr  = issue ? issue_addr : PAW'(i_cmd.word_index);

    // Operand and product stores.
    gf2pm_ram #(.WIDTH(WORD_W), .DEPTH(OPERAND_WORDS)) u_a_ram (
        .i_clk   (i_clk),
        .i_we    (do_load),
        .i_waddr (OAW'(i_cmd.word_index)),
        .i_wdata (i_cmd.a_word),
        .i_raddr (r_i),
        .o_rdata (a_dout)
    );

    gf2pm_ram #(.WIDTH(WORD_W), .DEPTH(OPERAND_WORDS)) u_b_ram (
        .i_clk   (i_clk),
        .i_we    (do_load),
        .i_waddr (OAW'(i_cmd.word_index)),
        .i_wdata (i_cmd.b_word),
        .i_raddr (r_j[OAW-1:0]),
        .o_rdata (b_dout)
    );

    gf2pm_ram #(.WIDTH(WORD_W), .DEPTH(PRODUCT_WORDS)) u_p_ram (
        .i_clk   (i_clk),
        .i_we    (r_s2_v),
        .i_waddr (r_s2_addr),
        .i_wdata (new_word),
        .i_raddr (p_raddr),
        .o_rdata (p_dout)
    );

    // Sequencer over rows i and columns j, with one tail step per row.
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_done  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (do_mul) begin
                    n_state = S_RUN;
                    n_i     = '0;
                    n_j     = '0;
                end
            end
            S_RUN: begin
                if (tail) begin
                    n_j = '0;
                    if (last_row) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_i = r_i + OAW'(1);
                    end
                end else begin
                    n_j = r_j + JW'(1);
                end
            end
            S_DRAIN: begin
                if (!r_s1_v && !r_s2_v) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_i       <= '0;
            r_j       <= '0;
            r_done    <= 1'b0;
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_i       <= n_i;
            r_j       <= n_j;
            r_done    <= n_done;
            r_s1_v    <= issue;
            r_s2_v    <= r_s1_v;
            r_rd_pend <= do_read;
        end
    end

    // Pipeline payload. Row zero and tail steps do not use the old product
    // word. Writes in flight never hit an entry being read for N >= 3.
    always_ff @(posedge i_clk) begin
        r_s1_addr <= issue_addr;
        r_s1_zold <= (r_i == '0) || tail;
        r_s1_tail <= tail;
        r_s1_j0   <= (r_j == '0);
        r_rd_zero <= ({2'b00, i_cmd.word_index} >= 10'(PRODUCT_WORDS));

        r_s2_addr <= r_s1_addr;
        r_s2_j0   <= r_s1_j0;
        r_old     <= r_s1_zold ? '0 : p_dout;
        if (r_s1_tail) begin
            r_pp <= '0;
        end else begin
            r_pp.ll <= clmul32(a_dout[HALF_W-1:0],      b_dout[HALF_W-1:0]);
            r_pp.lh <= clmul32(a_dout[HALF_W-1:0],      b_dout[WORD_W-1:HALF_W]);
            r_pp.hl <= clmul32(a_dout[WORD_W-1:HALF_W], b_dout[HALF_W-1:0]);
            r_pp.hh <= clmul32(a_dout[WORD_W-1:HALF_W], b_dout[WORD_W-1:HALF_W]);
        end
        if (r_s2_v) begin
            r_carry <= prod[2*WORD_W-1:WORD_W];
        end
    end

    // Combine partials into the 128-bit product and fold in the high half
    // left over from the previous column of the same row.
    assign prod = {{WORD_W{1'b0}}, r_pp.ll}
                ^ ({{WORD_W{1'b0}}, r_pp.lh ^ r_pp.hl} << HALF_W)
                ^ {r_pp.hh, {WORD_W{1'b0}}};
    assign carry_in = r_s2_j0 ? '0 : r_carry;
    assign new_word = r_old ^ prod[WORD_W-1:0] ^ carry_in;

    // Outputs.
    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_rd_pend || r_done;
    assign o_result.product_word = (r_rd_pend && !r_rd_zero) ? p_dout : '0;
    assign o_result.done_res     = r_done;

endmodule

FILE: rtl/gf2pm_checker.sv
module gf2pm_checker
    import gf2pm_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_start,
    input t_cmd    i_cmd,
    input logic    o_busy,
    input logic    o_strobe,
    input t_result o_result
);

    // A read request returns its word in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_start && !o_busy && i_cmd.operation == OP_READ)
        |=> (o_strobe && !o_result.done_res))
        else $error("read request without result in the next cycle");

    // A multiply request makes the block busy.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_start && !o_busy && i_cmd.operation == OP_MULTIPLY) |=> o_busy)
        else $error("multiply request did not raise busy");

    // A load gives no result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_start && !o_busy && i_cmd.operation == OP_LOAD) |=> !o_strobe)
        else $error("load request produced a result");

    // The done result carries a zero word and ends a busy period.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.done_res) |-> (o_result.product_word == '0 && $past(o_busy)))
        else $error("done result malformed or not after a multiply");

endmodule

bind gf2_polynomial_multiplier_unit gf2pm_checker u_gf2pm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .i_cmd    (i_cmd),
    .o_busy   (o_busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

FILE: sim/gf2pm_product_checker.sv
`timescale 1ns / 100ps

// Watches the request and result channels, keeps its own copy of the operand
// and product stores, predicts each result and compares it field by field.
module gf2pm_product_checker
    import gf2pm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_busy,
    input  t_cmd    i_cmd,
    input  logic    i_strobe,
    input  t_result i_result,
    output int      o_fail_count,
    output int      o_pending
);

    logic [WORD_W-1:0] a_words [OPERAND_WORDS];
    logic [WORD_W-1:0] b_words [OPERAND_WORDS];
    logic [WORD_W-1:0] product_words [PRODUCT_WORDS];
    t_result           awaited_results [$];

    // Full 64x64 carry-less product, high word in the upper half.
    function automatic logic [2*WORD_W-1:0] clmul64(input logic [WORD_W-1:0] x,
                                                    input logic [WORD_W-1:0] y);
        logic [2*WORD_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < WORD_W; k++) begin
            if (y[k]) begin
                acc = acc ^ ({{WORD_W{1'b0}}, x} << k);
            end
        end
        return acc;
    endfunction

    // Schoolbook product of the two stored polynomials.
    task automatic form_product();
        logic [2*WORD_W-1:0] pp;
        for (int k = 0; k < PRODUCT_WORDS; k++) begin
            product_words[k] = '0;
        end
        for (int i = 0; i < OPERAND_WORDS; i++) begin
            for (int j = 0; j < OPERAND_WORDS; j++) begin
                pp = clmul64(a_words[i], b_words[j]);
                product_words[i + j]     ^= pp[WORD_W-1:0];
                product_words[i + j + 1] ^= pp[2*WORD_W-1:WORD_W];
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result exp_res;
        t_result got;
        if (!i_rst_n) begin
            o_fail_count = 0;
            o_pending = 0;
        end else begin
            // Compare a result against the oldest prediction.
            if (i_strobe) begin
                got = i_result;
                if (awaited_results.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= 10) begin
                        $display("%0t: unexpected result word=%h done=%b",
                                 $realtime, got.product_word, got.done_res);
                    end
                end else begin
                    exp_res = awaited_results.pop_front();
                    if (got.product_word !== exp_res.product_word ||
                        got.done_res !== exp_res.done_res) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= 10) begin
                            $display("%0t: mismatch word exp=%h got=%h done exp=%b got=%b",
                                     $realtime, exp_res.product_word, got.product_word,
                                     exp_res.done_res, got.done_res);
                        end
                    end
                end
            end
            // Predict from each accepted request.
            if (i_start && !i_busy) begin
                case (i_cmd.operation)
                    OP_LOAD: begin
                        if (i_cmd.word_index < OPERAND_WORDS) begin
                            a_words[i_cmd.word_index[OAW-1:0]] = i_cmd.a_word;
                            b_words[i_cmd.word_index[OAW-1:0]] = i_cmd.b_word;
                        end
                    end
                    OP_MULTIPLY: begin
                        form_product();
                        exp_res.product_word = '0;
                        exp_res.done_res = 1'b1;
                        awaited_results.push_back(exp_res);
                    end
                    OP_READ: begin
                        exp_res.product_word = (i_cmd.word_index < PRODUCT_WORDS) ?
                                               product_words[i_cmd.word_index] : '0;
                        exp_res.done_res = 1'b0;
                        awaited_results.push_back(exp_res);
                    end
                    default: begin
                    end
                endcase
            end
            o_pending = awaited_results.size();
        end
    end

endmodule

FILE: sim/gf2_polynomial_multiplier_unit_tb.sv
`timescale 1ns / 100ps

module gf2_polynomial_multiplier_unit_tb
    import gf2pm_pkg::*;
;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    // The watchdog limit lies above the busy period of a multiply.
    localparam int STALL_LIMIT = 40000;
    localparam int ROUNDS = 10;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_start;
    t_cmd    i_cmd;
    logic    o_busy;
    logic    o_strobe;
    t_result o_result;
    int      fail_count;
    int      pending;
    int      idle_pct;
    int      quiet_cycles;

    gf2_polynomial_multiplier_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_cmd    (i_cmd),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    gf2pm_product_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_cmd        (i_cmd),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Coefficient words biased toward the extremes.
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Hold a request until the block takes it, then idle at random.
    task automatic issue(input logic [1:0] op, input int idx,
                         input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
        i_start <= 1'b1;
        i_cmd <= '{operation: op, word_index: idx[7:0], a_word: a, b_word: b};
        forever begin
            @(negedge i_clk);
            if (!o_busy) begin
                break;
            end
        end
        @(posedge i_clk);
        if ($urandom_range(1, 100) <= idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic load_word(input int idx);
        issue(OP_LOAD, idx, pick_word(), pick_word());
    endtask

    task automatic read_word(input int idx);
        issue(OP_READ, idx, pick_word(), pick_word());
    endtask

    // Watchdog on cycles with no request and no result taken.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        int count;
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_cmd <= '0;
        idle_pct = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every operand word with extremes at both ends, then the ignored
        // requests, a multiply, reads at the product edges and a second multiply.
        issue(OP_LOAD, 0, '1, '1);
        for (int k = 1; k < OPERAND_WORDS - 1; k++) begin
            load_word(k);
        end
        issue(OP_LOAD, OPERAND_WORDS - 1, '1, '1);
        issue(OP_LOAD, OPERAND_WORDS, '1, '1);
        issue(OP_LOAD, 255, '0, '1);
        issue(OP_UNUSED, 0, '1, '1);
        issue(OP_MULTIPLY, 0, '0, '0);
        read_word(0);
        read_word(1);
        read_word(PRODUCT_WORDS - 1);
        read_word(PRODUCT_WORDS);
        read_word(255);
        issue(OP_LOAD, 0, '0, '0);
        read_word(0);
        issue(OP_MULTIPLY, 255, '1, '1);
        read_word(0);
        read_word(PRODUCT_WORDS - 2);

        // Random rounds: reload part of the operands, multiply, read back.
        for (int r = 0; r < ROUNDS; r++) begin
            case (r % 4)
                0: idle_pct = 0;
                1: idle_pct = 57;
                2: idle_pct = 31;
                default: idle_pct = 0;
            endcase
            count = $urandom_range(1, OPERAND_WORDS);
            for (int k = 0; k < count; k++) begin
                if ($urandom_range(0, 19) == 0) begin
                    issue($urandom_range(0, 1) ? OP_UNUSED : OP_LOAD,
                          $urandom_range(0, 255), pick_word(), pick_word());
                end else begin
                    load_word($urandom_range(0, OPERAND_WORDS - 1));
                end
            end
            issue(OP_MULTIPLY, $urandom_range(0, 255), pick_word(), pick_word());
            for (int k = 0; k < 60; k++) begin
                case ($urandom_range(0, 9))
                    0: load_word($urandom_range(0, 255));
                    1: read_word($urandom_range(0, 255));
                    default: read_word($urandom_range(0, PRODUCT_WORDS - 1));
                endcase
            end
        end

        // Drain outstanding results, then wait before the verdict.
        i_start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/gf2pm_pkg.sv
rtl/gf2pm_ram.sv
rtl/gf2_polynomial_multiplier_unit.sv
rtl/gf2pm_checker.sv
sim/gf2pm_product_checker.sv
sim/gf2_polynomial_multiplier_unit_tb.sv
